/* hw/rtl/bfba_pkg.sv */
// Shared constants and controller/datapath interface types for the best-fit allocator.
package bfba_pkg;

	// Port widths fixed by the item format
	localparam int SIZE_PORT_BITS  = 16;
	localparam int INDEX_PORT_BITS = 3;
	localparam int CFG_BITS        = 4;

	// Defaults for the top-level parameters
	localparam int NUM_BLOCKS_DEF = 8;
	localparam int SIZE_BITS_DEF  = 16;

	// Block count register
	localparam logic [CFG_BITS-1:0] BLOCK_COUNT_RESET = CFG_BITS'(8);
	localparam int                  BLOCK_COUNT_MAX   = (1 << CFG_BITS) - 1;

	// Item kinds
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_PLACE = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;    // load item transferred: write one capacity
		logic start;   // request transferred: capture size, clear best match
		logic issue;   // read the next capacity of the scan
		logic commit;  // write back the best block and load the result register
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic limit_zero;  // no block takes part in the search
		logic issue_last;  // this read is the last of the scan
	} dp_status_t;

endpackage

/* hw/rtl/bfba_ctrl.sv */
// Controller state machine: input/output handshake and scan sequencing.
module bfba_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 req_type,
	output logic                 out_valid,
	input  logic                 out_stall,
	output bfba_pkg::dp_cmd_t    cmd,
	input  bfba_pkg::dp_status_t status
);
	import bfba_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;

	// Decode commands from the current state
	always_comb begin
		accept      = in_valid && (state_q == ST_IDLE);
		cmd.load    = accept && (req_type == REQ_LOAD);
		cmd.start   = accept && (req_type == REQ_PLACE);
		cmd.issue   = (state_q == ST_SCAN);
		cmd.commit  = (state_q == ST_COMMIT) && (!out_valid_q || !out_stall);
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Advance state and hold the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= status.limit_zero ? ST_COMMIT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (status.issue_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/bfba_dp.sv */
// Datapath: capacity memory, serial best-fit comparator, update and result register.
module bfba_dp #(
	parameter int NUM_BLOCKS = bfba_pkg::NUM_BLOCKS_DEF,
	parameter int SIZE_BITS  = bfba_pkg::SIZE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  bfba_pkg::dp_cmd_t                    cmd,
	output bfba_pkg::dp_status_t                 status,
	input  logic [bfba_pkg::INDEX_PORT_BITS-1:0] block_index,
	input  logic [bfba_pkg::SIZE_PORT_BITS-1:0]  size_value,
	input  logic                                 cfg_we,
	input  logic [bfba_pkg::CFG_BITS-1:0]        cfg_wdata,
	output logic                                 placed,
	output logic [bfba_pkg::INDEX_PORT_BITS-1:0] chosen_block,
	output logic [bfba_pkg::SIZE_PORT_BITS-1:0]  remaining_after
);
	import bfba_pkg::*;

	localparam int IDX_BITS  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int LIMIT_MAX = (NUM_BLOCKS < BLOCK_COUNT_MAX) ? NUM_BLOCKS : BLOCK_COUNT_MAX;
	localparam int CNT_BITS  = (LIMIT_MAX > 1) ? $clog2(LIMIT_MAX + 1) : 1;
	localparam int IN_BITS   = (SIZE_BITS < SIZE_PORT_BITS) ? SIZE_BITS : SIZE_PORT_BITS;
	localparam int OUT_IDX   = (IDX_BITS < INDEX_PORT_BITS) ? IDX_BITS : INDEX_PORT_BITS;

	logic [SIZE_BITS-1:0] cap_mem_q [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] valid_q;

	logic [CFG_BITS-1:0]  count_q;
	logic [CNT_BITS-1:0]  limit;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [CNT_BITS:0]    cnt_nxt;
	logic [SIZE_BITS-1:0] size_w;
	logic [SIZE_BITS-1:0] size_q;

	logic [IDX_BITS-1:0]  rd_addr;
	logic [SIZE_BITS-1:0] rd_data_s1;
	logic                 rd_hit_s1;
	logic [IDX_BITS-1:0]  rd_idx_s1;
	logic                 cmp_en_s1;
	logic [SIZE_BITS-1:0] cand;
	logic                 take;

	logic                 found_q;
	logic [IDX_BITS-1:0]  best_idx_q;
	logic [SIZE_BITS-1:0] best_val_q;
	logic [SIZE_BITS-1:0] diff;

	logic                 load_ok;
	logic                 wr_en;
	logic [IDX_BITS-1:0]  wr_addr;
	logic [SIZE_BITS-1:0] wr_data;

	logic [INDEX_PORT_BITS-1:0] idx_out;
	logic [SIZE_PORT_BITS-1:0]  diff_out;

	logic                       placed_q;
	logic [INDEX_PORT_BITS-1:0] chosen_q;
	logic [SIZE_PORT_BITS-1:0]  remain_q;

	// Hold the block count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= BLOCK_COUNT_RESET;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// Saturate the count to the number of blocks
	always_comb begin
		if (int'(count_q) > NUM_BLOCKS) begin
			limit = CNT_BITS'(NUM_BLOCKS);
		end else begin
			limit = CNT_BITS'(count_q);
		end
	end

	assign cnt_nxt           = {1'b0, cnt_q} + (CNT_BITS + 1)'(1);
	assign status.limit_zero = (limit == '0);
	assign status.issue_last = (cnt_nxt == {1'b0, limit});

	// Mask the incoming size to the storage width
	always_comb begin
		size_w = '0;
		for (int i = 0; i < IN_BITS; i++) begin
			size_w[i] = size_value[i];
		end
	end

	// Advance the scan counter and capture the requested size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start) begin
			cnt_q <= '0;
		end else if (cmd.issue) begin
			cnt_q <= cnt_nxt[CNT_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			size_q <= size_w;
		end
	end

	// Select the single write port source
	always_comb begin
		load_ok = (int'(block_index) < NUM_BLOCKS);
		diff    = best_val_q - size_q;
		if (cmd.commit) begin
			wr_en   = found_q;
			wr_addr = best_idx_q;
			wr_data = diff;
		end else begin
			wr_en   = cmd.load && load_ok;
			wr_addr = IDX_BITS'(block_index);
			wr_data = size_w;
		end
	end

	// Capacity memory, written at one address
	always_ff @(posedge clk) begin
		if (wr_en) begin
			cap_mem_q[wr_addr] <= wr_data;
		end
	end

	// Mark written entries; unwritten ones read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// Registered read at the scan address
	assign rd_addr = IDX_BITS'(cnt_q);

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rd_data_s1 <= cap_mem_q[rd_addr];
			rd_hit_s1  <= valid_q[rd_addr];
			rd_idx_s1  <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_en_s1 <= 1'b0;
		end else begin
			cmp_en_s1 <= cmd.issue;
		end
	end

	// Compare the candidate against the best match so far
	always_comb begin
		cand = rd_hit_s1 ? rd_data_s1 : '0;
		take = cmp_en_s1 && (cand >= size_q) && (!found_q || (cand < best_val_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.start) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q <= rd_idx_s1;
			best_val_q <= cand;
		end
	end

	// Fit index and remainder to the result fields
	always_comb begin
		idx_out  = '0;
		diff_out = '0;
		for (int i = 0; i < OUT_IDX; i++) begin
			idx_out[i] = best_idx_q[i];
		end
		for (int i = 0; i < IN_BITS; i++) begin
			diff_out[i] = diff[i];
		end
	end

	// Load the result register on commit
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			placed_q <= found_q;
			chosen_q <= found_q ? idx_out : '0;
			remain_q <= found_q ? diff_out : '0;
		end
	end

	assign placed          = placed_q;
	assign chosen_block    = chosen_q;
	assign remaining_after = remain_q;

endmodule

/* hw/rtl/best_fit_block_allocator.sv */
// Best-fit block allocator: top level joining controller and datapath.
//
// Input channel (in_valid / in_stall) carries one item: req_type selects a load
// (write size_value as the capacity of block block_index) or a placement request
// of size size_value. A transfer happens when in_valid is high and in_stall low.
// Loads produce no result; each request produces one result on the output channel
// (out_valid / out_stall): placed, chosen_block and remaining_after.
//
// Sequence: a load is written at its transfer; the next item may follow at once.
// A request scans the first N blocks, where N is the block count saturated to
// NUM_BLOCKS: one capacity read per cycle through the single read port feeding
// one comparator, then a drain state for the last compare, then the write-back
// state, which loads the result register. A count of zero skips the scan and the
// drain. in_stall stays high until the write-back, so no item is taken meanwhile.
//
// The result sits in an output register; while the receiver stalls, the block
// still takes the next item and works on it, and only holds at its write-back
// until the waiting result has been transferred.
//
// Reset makes all capacities read as zero, sets the block count to 8 and clears both channels.
module best_fit_block_allocator #(
	parameter int NUM_BLOCKS = bfba_pkg::NUM_BLOCKS_DEF,
	parameter int SIZE_BITS  = bfba_pkg::SIZE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 req_type,
	input  logic [bfba_pkg::INDEX_PORT_BITS-1:0] block_index,
	input  logic [bfba_pkg::SIZE_PORT_BITS-1:0]  size_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 placed,
	output logic [bfba_pkg::INDEX_PORT_BITS-1:0] chosen_block,
	output logic [bfba_pkg::SIZE_PORT_BITS-1:0]  remaining_after,
	input  logic                                 cfg_we,
	input  logic [bfba_pkg::CFG_BITS-1:0]        cfg_wdata
);
	import bfba_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequence the handshake and scan
	bfba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	// Store capacities and run the best-fit search
	bfba_dp #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.SIZE_BITS  (SIZE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.block_index     (block_index),
		.size_value      (size_value),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.placed          (placed),
		.chosen_block    (chosen_block),
		.remaining_after (remaining_after)
	);

endmodule

/* hw/rtl/bfba_check.sv */
// Port-level checker for the best-fit allocator, bound to the top level.
module bfba_check (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_stall,
	input logic                                 req_type,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic                                 placed,
	input logic [bfba_pkg::INDEX_PORT_BITS-1:0] chosen_block,
	input logic [bfba_pkg::SIZE_PORT_BITS-1:0]  remaining_after
);
	import bfba_pkg::*;

	// A request transfer leaves the idle state, so input is held the next cycle
	a_req_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (req_type == REQ_PLACE) |=> in_stall)
		else $error("input not held after request transfer");

	// A load transfer leaves the input free in the cycle after it
	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (req_type == REQ_LOAD) |=> !in_stall)
		else $error("input held after load transfer");

	// A result that was not placed carries zero index and remainder
	a_unplaced_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !placed |-> (chosen_block == '0) && (remaining_after == '0))
		else $error("unplaced result with nonzero fields");

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(placed)
			&& $stable(chosen_block) && $stable(remaining_after))
		else $error("stalled result changed");

endmodule

bind best_fit_block_allocator bfba_check u_check (.*);
